FILE: sv/assert_macros.svh
// assertion macros shared by the rtl
// needs clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RAP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rap assertion failed");

// condition must never be seen out of reset
`define RAP_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rap forbidden condition seen");

`endif

FILE: sv/rap_pkg.sv
// rotate and project point: widths, types, register indexes and helpers
// no dependencies
package rap_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int REG_BITS       = 16;
    localparam int IDX_BITS       = 3;
    localparam int MID_BITS       = COORD_BITS + 6;
    localparam int P1_BITS        = COORD_BITS + REG_BITS;
    localparam int P2_BITS        = MID_BITS + REG_BITS;
    localparam int SUM_BITS       = P2_BITS + 2;
    localparam int D_BITS         = ((REG_BITS + 1 > MID_BITS) ? REG_BITS + 1 : MID_BITS) + 1;
    localparam int N_BITS         = REG_BITS + 1 + MID_BITS;
    localparam int Q_BITS         = COORD_BITS + 1;
    localparam int R_BITS         = ((N_BITS > D_BITS + Q_BITS) ? N_BITS : D_BITS + Q_BITS) + 1;

    localparam logic [IDX_BITS-1:0] REG_COS_X = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_SIN_X = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_COS_Y = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_SIN_Y = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] REG_COS_Z = IDX_BITS'(4);
    localparam logic [IDX_BITS-1:0] REG_SIN_Z = IDX_BITS'(5);
    localparam logic [IDX_BITS-1:0] REG_FOCAL = IDX_BITS'(6);

    localparam logic [REG_BITS-1:0] COS_RESET   = REG_BITS'(16384);
    localparam logic [REG_BITS-1:0] SIN_RESET   = REG_BITS'(0);
    localparam logic [REG_BITS-1:0] FOCAL_RESET = REG_BITS'(25600);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [MID_BITS-1:0]   mid_t;
    typedef logic signed [REG_BITS-1:0]   trig_t;
    typedef logic signed [D_BITS-1:0]     denom_t;

    typedef struct packed {
        logic behind;
        logic last;
    } tag_t;

    // shift right by the trig fraction, round half up, saturate to mid width
    function automatic mid_t round_sat(input logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS:0] t;
        mid_t                     r;
        t = s;
        t = t + ((SUM_BITS+1)'(1) <<< (TRIG_FRAC_BITS - 1));
        t = t >>> TRIG_FRAC_BITS;
        if (t[SUM_BITS:MID_BITS-1] == {(SUM_BITS-MID_BITS+2){1'b0}} ||
            t[SUM_BITS:MID_BITS-1] == {(SUM_BITS-MID_BITS+2){1'b1}})
            r = t[MID_BITS-1:0];
        else if (t[SUM_BITS])
            r = {1'b1, {(MID_BITS-1){1'b0}}};
        else
            r = {1'b0, {(MID_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: sv/rap_if.sv
// request channels of the rotate and project block
// uses rap_pkg
interface rap_point_if;
    logic            valid;
    logic            ready;
    rap_pkg::coord_t pt_x;
    rap_pkg::coord_t pt_y;
    rap_pkg::coord_t pt_z;
    logic            last_point;
    modport source (output valid, output pt_x, output pt_y, output pt_z,
                    output last_point, input ready);
    modport sink   (input valid, input pt_x, input pt_y, input pt_z,
                    input last_point, output ready);
endinterface

interface rap_result_if;
    logic            valid;
    logic            ready;
    rap_pkg::coord_t screen_x;
    rap_pkg::coord_t screen_y;
    logic            behind_viewer;
    logic            clipped;
    logic            last_out;
    modport source (output valid, output screen_x, output screen_y,
                    output behind_viewer, output clipped, output last_out,
                    input ready);
    modport sink   (input valid, input screen_x, input screen_y,
                    input behind_viewer, input clipped, input last_out,
                    output ready);
endinterface

FILE: sv/rap_rotate.sv
// six stage rotation about x, y then z, plus perspective denominator
// uses rap_pkg
module rap_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rap_pkg::coord_t x,
    input  rap_pkg::coord_t y,
    input  rap_pkg::coord_t z,
    input  logic            last,
    input  rap_pkg::trig_t  cx,
    input  rap_pkg::trig_t  sx,
    input  rap_pkg::trig_t  cy,
    input  rap_pkg::trig_t  sy,
    input  rap_pkg::trig_t  cz,
    input  rap_pkg::trig_t  sz,
    input  logic [rap_pkg::REG_BITS-1:0] f,
    output logic            out_valid,
    output rap_pkg::mid_t   x3,
    output rap_pkg::mid_t   y3,
    output rap_pkg::denom_t d,
    output rap_pkg::tag_t   tag
);

    localparam int SB = rap_pkg::SUM_BITS;

    logic [5:0] vld_reg;
    logic [4:0] last_reg;

    logic signed [rap_pkg::P1_BITS-1:0] ycx_reg, zsx_reg, ysx_reg, zcx_reg;
    rap_pkg::coord_t x_s1_reg, x_s2_reg;
    rap_pkg::mid_t   y1_s2_reg, z1_s2_reg, y1_s3_reg, y1_s4_reg;
    logic signed [rap_pkg::P2_BITS-1:0] xcy_reg, z1sy_reg, xsy_reg, z1cy_reg;
    rap_pkg::mid_t   x2_reg, z2_s4_reg, z2_s5_reg;
    logic signed [rap_pkg::P2_BITS-1:0] x2cz_reg, y1sz_reg, x2sz_reg, y1cz_reg;
    rap_pkg::mid_t   x3_reg, y3_reg;
    rap_pkg::denom_t d_reg, d_next;
    rap_pkg::tag_t   tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            last_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[4:0], in_valid};
            last_reg <= {last_reg[3:0], last};
        end
    end

    assign d_next = rap_pkg::D_BITS'($signed({1'b0, f})) + rap_pkg::D_BITS'(z2_s5_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // about x
            ycx_reg   <= y * cx;
            zsx_reg   <= z * sx;
            ysx_reg   <= y * sx;
            zcx_reg   <= z * cx;
            x_s1_reg  <= x;
            y1_s2_reg <= rap_pkg::round_sat(SB'(ycx_reg) + SB'(zsx_reg));
            z1_s2_reg <= rap_pkg::round_sat(SB'(zcx_reg) - SB'(ysx_reg));
            x_s2_reg  <= x_s1_reg;
            // about y
            xcy_reg   <= x_s2_reg * cy;
            z1sy_reg  <= z1_s2_reg * sy;
            xsy_reg   <= x_s2_reg * sy;
            z1cy_reg  <= z1_s2_reg * cy;
            y1_s3_reg <= y1_s2_reg;
            x2_reg    <= rap_pkg::round_sat(SB'(xcy_reg) - SB'(z1sy_reg));
            z2_s4_reg <= rap_pkg::round_sat(SB'(xsy_reg) + SB'(z1cy_reg));
            y1_s4_reg <= y1_s3_reg;
            // about z
            x2cz_reg  <= x2_reg * cz;
            y1sz_reg  <= y1_s4_reg * sz;
            x2sz_reg  <= x2_reg * sz;
            y1cz_reg  <= y1_s4_reg * cz;
            z2_s5_reg <= z2_s4_reg;
            x3_reg    <= rap_pkg::round_sat(SB'(x2cz_reg) + SB'(y1sz_reg));
            y3_reg    <= rap_pkg::round_sat(SB'(y1cz_reg) - SB'(x2sz_reg));
            d_reg     <= d_next;
            tag_reg.behind <= d_next[rap_pkg::D_BITS-1] || (d_next == '0);
            tag_reg.last   <= last_reg[4];
        end
    end

    assign out_valid = vld_reg[5];
    assign x3        = x3_reg;
    assign y3        = y3_reg;
    assign d         = d_reg;
    assign tag       = tag_reg;

endmodule

FILE: sv/rap_div.sv
// one projection lane: focal multiply, restoring divide one bit per stage,
// sign and saturation; uses rap_pkg
module rap_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rap_pkg::mid_t   coord,
    input  logic [rap_pkg::REG_BITS-1:0] f,
    input  rap_pkg::denom_t d,
    input  rap_pkg::tag_t   tag_in,
    output logic            out_valid,
    output rap_pkg::coord_t result,
    output logic            clip,
    output rap_pkg::tag_t   tag_out
);

    localparam int QB = rap_pkg::Q_BITS;
    localparam int RB = rap_pkg::R_BITS;
    localparam int CB = rap_pkg::COORD_BITS;
    localparam int DM = rap_pkg::D_BITS - 1;

    logic                               v1_reg;
    logic signed [rap_pkg::N_BITS-1:0]  prod_reg;
    rap_pkg::denom_t                    d1_reg;
    rap_pkg::tag_t                      tag1_reg;

    logic                               vld_reg [0:QB];
    logic [RB-1:0]                      rem_reg [0:QB];
    logic [QB-1:0]                      q_reg   [0:QB];
    logic [DM-1:0]                      dm_reg  [0:QB];
    logic                               neg_reg [0:QB];
    logic                               over_reg[0:QB];
    rap_pkg::tag_t                      tag_reg [0:QB];

    logic [RB-1:0] mag_next;
    logic [DM-1:0] dm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= in_valid;
            vld_reg[0] <= v1_reg;
        end
    end

    assign mag_next = prod_reg[rap_pkg::N_BITS-1] ? RB'(-prod_reg) : RB'(prod_reg);
    assign dm_next  = d1_reg[DM-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= $signed({1'b0, f}) * coord;
            d1_reg      <= d;
            tag1_reg    <= tag_in;
            rem_reg[0]  <= mag_next;
            q_reg[0]    <= '0;
            dm_reg[0]   <= dm_next;
            neg_reg[0]  <= prod_reg[rap_pkg::N_BITS-1];
            over_reg[0] <= mag_next >= (RB'(dm_next) << QB);
            tag_reg[0]  <= tag1_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int BIT = QB - 1 - k;
        logic [RB-1:0] trial;
        logic          fits;

        assign trial = RB'(dm_reg[k]) << BIT;
        assign fits  = rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= fits ? rem_reg[k] - trial : rem_reg[k];
                q_reg[k+1]    <= q_reg[k] | (fits ? QB'(1) << BIT : QB'(0));
                dm_reg[k+1]   <= dm_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                over_reg[k+1] <= over_reg[k];
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    logic [QB-1:0] q;
    assign q = q_reg[QB];

    // truncated quotient, signed and saturated; zero for a point behind the viewer
    always_comb
    begin
        clip   = 1'b0;
        result = '0;
        if (tag_reg[QB].behind)
        begin
            clip   = 1'b0;
            result = '0;
        end
        else if (!neg_reg[QB])
        begin
            if (over_reg[QB] || q[CB:CB-1] != 2'b00)
            begin
                clip   = 1'b1;
                result = {1'b0, {(CB-1){1'b1}}};
            end
            else
                result = q[CB-1:0];
        end
        else
        begin
            if (over_reg[QB] || q[CB] || (q[CB-1] && q[CB-2:0] != '0))
            begin
                clip   = 1'b1;
                result = {1'b1, {(CB-1){1'b0}}};
            end
            else
                result = -q[CB-1:0];
        end
    end

    assign out_valid = vld_reg[QB];
    assign tag_out   = tag_reg[QB];

endmodule

FILE: sv/rotate_and_project_point.sv
// rotate and project point: top level with register file, lanes and result register
// uses rap_pkg, rap_if, rap_rotate, rap_div and assert_macros.svh
//
// One point is taken per clock and one result leaves per clock while the
// result register is not held; a point passes through six stages of rotation
// (multiply then round for each axis), a focal multiply and a magnitude
// stage, one restoring-divide stage per quotient bit (17 for 16-bit
// coordinates), and the result register. The whole pipe holds when the
// result register is full and not taken. Registers must be written only
// while no point is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module rotate_and_project_point (
    input  logic                          clk,
    input  logic                          rst_n,
    rap_point_if.sink                     point,
    rap_result_if.source                  result,
    input  logic                          wr_en,
    input  logic [rap_pkg::IDX_BITS-1:0]  wr_index,
    input  logic [rap_pkg::REG_BITS-1:0]  wr_data
);

    logic [rap_pkg::REG_BITS-1:0] cx_reg, sx_reg, cy_reg, sy_reg, cz_reg, sz_reg, f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= rap_pkg::COS_RESET;
            sx_reg <= rap_pkg::SIN_RESET;
            cy_reg <= rap_pkg::COS_RESET;
            sy_reg <= rap_pkg::SIN_RESET;
            cz_reg <= rap_pkg::COS_RESET;
            sz_reg <= rap_pkg::SIN_RESET;
            f_reg  <= rap_pkg::FOCAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rap_pkg::REG_COS_X: cx_reg <= wr_data;
                rap_pkg::REG_SIN_X: sx_reg <= wr_data;
                rap_pkg::REG_COS_Y: cy_reg <= wr_data;
                rap_pkg::REG_SIN_Y: sy_reg <= wr_data;
                rap_pkg::REG_COS_Z: cz_reg <= wr_data;
                rap_pkg::REG_SIN_Z: sz_reg <= wr_data;
                rap_pkg::REG_FOCAL: f_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || result.ready;
    assign point.ready = en;

    logic            rot_valid;
    rap_pkg::mid_t   rot_x, rot_y;
    rap_pkg::denom_t rot_d;
    rap_pkg::tag_t   rot_tag;

    rap_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (point.valid),
        .x         (point.pt_x),
        .y         (point.pt_y),
        .z         (point.pt_z),
        .last      (point.last_point),
        .cx        (rap_pkg::trig_t'(cx_reg)),
        .sx        (rap_pkg::trig_t'(sx_reg)),
        .cy        (rap_pkg::trig_t'(cy_reg)),
        .sy        (rap_pkg::trig_t'(sy_reg)),
        .cz        (rap_pkg::trig_t'(cz_reg)),
        .sz        (rap_pkg::trig_t'(sz_reg)),
        .f         (f_reg),
        .out_valid (rot_valid),
        .x3        (rot_x),
        .y3        (rot_y),
        .d         (rot_d),
        .tag       (rot_tag)
    );

    logic            vx, vy, clip_x, clip_y;
    rap_pkg::coord_t px, py;
    rap_pkg::tag_t   tag_x, tag_y;

    rap_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .coord     (rot_x),
        .f         (f_reg),
        .d         (rot_d),
        .tag_in    (rot_tag),
        .out_valid (vx),
        .result    (px),
        .clip      (clip_x),
        .tag_out   (tag_x)
    );

    rap_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .coord     (rot_y),
        .f         (f_reg),
        .d         (rot_d),
        .tag_in    (rot_tag),
        .out_valid (vy),
        .result    (py),
        .clip      (clip_y),
        .tag_out   (tag_y)
    );

    rap_pkg::coord_t sx_out_reg, sy_out_reg;
    logic            behind_reg, clip_reg, last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_out_reg <= px;
            sy_out_reg <= py;
            behind_reg <= tag_x.behind;
            clip_reg   <= clip_x || clip_y;
            last_reg   <= tag_x.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.screen_x      = sx_out_reg;
    assign result.screen_y      = sy_out_reg;
    assign result.behind_viewer = behind_reg;
    assign result.clipped       = clip_reg;
    assign result.last_out      = last_reg;

    // both lanes carry the same request in step
    `RAP_ASSERT(a_lanes_in_step, vx == vy && (!vx || tag_x == tag_y))
    // a point behind the viewer gives a zero, unclipped result
    `RAP_NEVER(a_behind_zero, out_valid_reg && behind_reg &&
        (sx_out_reg != '0 || sy_out_reg != '0 || clip_reg))
    // a held result stalls the whole pipe
    `RAP_ASSERT(a_stall_holds_input, (out_valid_reg && !result.ready) |-> !point.ready)

endmodule

FILE: dv/rap_checker.sv
// checker for rotate_and_project_point: predicts each projected point and compares results
// depends on rap_pkg and the channel interfaces in rap_if.sv
module rap_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    rap_point_if                          point,
    rap_result_if                         result,
    input  logic                          wr_en,
    input  logic [rap_pkg::IDX_BITS-1:0]  wr_index,
    input  logic [rap_pkg::REG_BITS-1:0]  wr_data,
    output int                            errors,
    output int                            pending
);
    import rap_pkg::*;

    typedef struct {
        coord_t sx;
        coord_t sy;
        logic   behind;
        logic   clip;
        logic   last;
    } screen_pt_t;

    trig_t              coef [6];
    logic [REG_BITS-1:0] focal;
    screen_pt_t         screen_q [$];

    function automatic longint rot_mac(longint a, longint c, longint b, longint s);
        longint sum;
        longint lim;
        sum = a * c + b * s + (longint'(1) <<< (TRIG_FRAC_BITS - 1));
        sum = sum >>> TRIG_FRAC_BITS;
        lim = longint'(1) <<< (MID_BITS - 1);
        if (sum > lim - 1)
            return lim - 1;
        if (sum < -lim)
            return -lim;
        return sum;
    endfunction

    function automatic longint clamp_coord(longint v, ref logic hit);
        longint lim;
        lim = longint'(1) <<< (COORD_BITS - 1);
        if (v > lim - 1)
        begin
            hit = 1'b1;
            return lim - 1;
        end
        if (v < -lim)
        begin
            hit = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic screen_pt_t project_point(coord_t px, coord_t py, coord_t pz, logic lst);
        screen_pt_t r;
        longint cx, sx, cy, sy, cz, sz, f;
        longint y1, z1, x2, z2, x3, y3, d;
        logic   hit;
        cx = coef[0]; sx = coef[1];
        cy = coef[2]; sy = coef[3];
        cz = coef[4]; sz = coef[5];
        f  = longint'(focal);
        y1 = rot_mac(px * 0 + py, cx, pz, sx);
        z1 = rot_mac(py, -sx, pz, cx);
        x2 = rot_mac(px, cy, z1, -sy);
        z2 = rot_mac(px, sy, z1, cy);
        x3 = rot_mac(x2, cz, y1, sz);
        y3 = rot_mac(x2, -sz, y1, cz);
        d  = f + z2;
        hit = 1'b0;
        r.sx = '0;
        r.sy = '0;
        r.behind = (d <= 0);
        if (!r.behind)
        begin
            r.sx = coord_t'(clamp_coord((f * x3) / d, hit));
            r.sy = coord_t'(clamp_coord((f * y3) / d, hit));
        end
        r.clip = hit;
        r.last = lst;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_pt_t e;
        if (!rst_n)
        begin
            coef[0] <= COS_RESET; coef[1] <= SIN_RESET;
            coef[2] <= COS_RESET; coef[3] <= SIN_RESET;
            coef[4] <= COS_RESET; coef[5] <= SIN_RESET;
            focal   <= FOCAL_RESET;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_FOCAL)
                    focal <= wr_data;
                else if (wr_index < REG_FOCAL)
                    coef[wr_index] <= wr_data;
            end
            if (point.valid && point.ready)
                screen_q.push_back(project_point(point.pt_x, point.pt_y, point.pt_z,
                                                 point.last_point));
            if (result.valid && result.ready)
            begin
                if (screen_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result at %0t", $time);
                    errors <= errors + 1;
                end
                else
                begin
                    e = screen_q.pop_front();
                    if (result.screen_x !== e.sx || result.screen_y !== e.sy ||
                        result.behind_viewer !== e.behind || result.clipped !== e.clip ||
                        result.last_out !== e.last)
                    begin
                        if (errors < 10)
                            $display("mismatch at %0t: exp x=%0d y=%0d b=%0b c=%0b l=%0b got x=%0d y=%0d b=%0b c=%0b l=%0b",
                                     $time, e.sx, e.sy, e.behind, e.clip, e.last,
                                     result.screen_x, result.screen_y, result.behind_viewer,
                                     result.clipped, result.last_out);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= screen_q.size();
        end
    end
endmodule

FILE: dv/testbench.sv
// testbench top for rotate_and_project_point: clock, reset, register writes, point stimulus
// depends on rap_pkg, rap_if.sv, rap_checker and the block itself
module testbench;
    import rap_pkg::*;

    localparam logic [IDX_BITS-1:0] REG_UNUSED = IDX_BITS'(7);
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 100;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [IDX_BITS-1:0] wr_index;
    logic [REG_BITS-1:0] wr_data;
    int errors;
    int pending;
    int tx_idle;
    int rx_idle;
    int sent;

    rap_point_if  point ();
    rap_result_if result ();

    rotate_and_project_point dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    rap_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge clk)
        result.ready <= rst_n && ($urandom_range(99) >= rx_idle);

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
    endtask

    function automatic logic [REG_BITS-1:0] rand_trig();
        return REG_BITS'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_point(coord_t x, coord_t y, coord_t z, logic lst);
        while ($urandom_range(99) < tx_idle)
        begin
            point.valid <= 1'b0;
            @(negedge clk);
        end
        point.valid      <= 1'b1;
        point.pt_x       <= x;
        point.pt_y       <= y;
        point.pt_z       <= z;
        point.last_point <= lst;
        do
            @(posedge clk);
        while (!point.ready);
        @(negedge clk);
        sent++;
        if (sent == 3 * PHASE_ITEMS)
        begin
            tx_idle = 83;
            rx_idle = 38;
        end
        else if (sent == 6 * PHASE_ITEMS)
        begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    task automatic set_phase(int ph);
        int k;
        case (ph)
            1:
            begin
                for (k = 0; k < 6; k++)
                    write_reg(IDX_BITS'(k), REG_BITS'(-16384));
                write_reg(REG_FOCAL, 16'hffff);
            end
            2:
            begin
                for (k = 0; k < 6; k++)
                    write_reg(IDX_BITS'(k), REG_BITS'(16384));
                write_reg(REG_FOCAL, 16'd1);
            end
            3:
            begin
                write_reg(REG_FOCAL, 16'd0);
                write_reg(REG_UNUSED, 16'h5a5a);
            end
            default:
            begin
                for (k = 0; k < 6; k++)
                    write_reg(IDX_BITS'(k), rand_trig());
                write_reg(REG_FOCAL, REG_BITS'($urandom_range(65535, 1)));
            end
        endcase
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_point();
        coord_t x, y, z;
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
        if ($urandom_range(1))
        begin
            x = x >>> $urandom_range(12);
            y = y >>> $urandom_range(12);
            z = z >>> $urandom_range(12);
        end
        send_point(x, y, z, $urandom_range(7) == 0);
    endtask

    initial
    begin
        int ph;
        int n;
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = '0;
        wr_data          = '0;
        point.valid      = 1'b0;
        point.pt_x       = '0;
        point.pt_y       = '0;
        point.pt_z       = '0;
        point.last_point = 1'b0;
        result.ready     = 1'b0;
        tx_idle          = 38;
        rx_idle          = 83;
        sent             = 0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, clipping and points behind the viewer at reset angles
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, -16'sd32768, 16'sd0, 1'b1);
        send_point(-16'sd32768, 16'sd32767, -16'sd25500, 1'b0);
        send_point(16'sd32767, 16'sd32767, -16'sd25599, 1'b1);
        send_point(16'sd100, -16'sd100, -16'sd25600, 1'b0);
        send_point(16'sd256, 16'sd512, 16'sd0, 1'b1);
        send_point(-16'sd1, 16'sd1, -16'sd1, 1'b0);
        send_point(16'sh5555, 16'shaaaa, 16'sh5555, 1'b1);
        send_point(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                point.valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                repeat (4)
                    @(negedge clk);
                set_phase(ph);
                if (ph <= 3)
                begin
                    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
                    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
                    send_point(16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
                end
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                random_point();
        end
        point.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: rotate_and_project_point.f
+incdir+sv
sv/rap_pkg.sv
sv/rap_if.sv
sv/rap_rotate.sv
sv/rap_div.sv
sv/rotate_and_project_point.sv
dv/rap_checker.sv
dv/testbench.sv
